// ===== rtl/complex_matrix_product_adjoint_assert.svh =====
// Assertion macros for the complex matrix product block.
// Used by the top level only; no dependencies.
`ifndef COMPLEX_MATRIX_PRODUCT_ADJOINT_ASSERT_SVH
`define COMPLEX_MATRIX_PRODUCT_ADJOINT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CMPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CMPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/cmpa_pkg.sv =====
// Shared types and constants for the complex matrix product block.
// No dependencies.
`default_nettype none
package cmpa_pkg;
    localparam int DIM_DEF = 3;
    localparam int FRAC_BITS_DEF = 28;
    localparam int ACC_W = 72;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_MUL    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic               adjoint_first;
        logic               adjoint_second;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_real;
        logic signed [31:0] out_imag;
        logic               last_of_run;
    } out_item_t;

    // multiply command passed from front to back
    typedef struct packed {
        logic adj1;
        logic adj2;
    } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/cmpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cmpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/cmpa_front.sv =====
// Front end: accepts items, writes loads to the matrix RAMs, queues multiplies.
// Depends on cmpa_pkg.
`default_nettype none
module cmpa_front #(
    parameter int DIM = cmpa_pkg::DIM_DEF,
    localparam int AW = $clog2(DIM * DIM)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire cmpa_pkg::in_item_t in_item,
    output logic                   we_a,
    output logic                   we_b,
    output logic [AW-1:0]          waddr,
    output logic [63:0]            wdata,
    output logic                   cmd_valid,
    output cmpa_pkg::cmd_t         cmd,
    input  wire logic              cmd_take,
    input  wire logic              busy
);
    logic          q_valid_reg, q_valid_next;
    cmpa_pkg::cmd_t q_cmd_reg;
    logic          accept, in_range, is_mul;
    logic [2*AW-1:0] idx;

    // hold all items while a multiply waits or runs
    assign full      = q_valid_reg || busy;
    assign accept    = push && !full;
    assign in_range  = (32'(in_item.row) < DIM) && (32'(in_item.col) < DIM);
    assign idx       = (2*AW)'(in_item.row) * (2*AW)'(DIM) + (2*AW)'(in_item.col);
    assign waddr     = idx[AW-1:0];
    assign wdata     = {in_item.imag_part, in_item.real_part};
    assign we_a      = accept && in_range && (in_item.action == cmpa_pkg::ACT_LOAD_A);
    assign we_b      = accept && in_range && (in_item.action == cmpa_pkg::ACT_LOAD_B);
    assign is_mul    = accept && (in_item.action == cmpa_pkg::ACT_MUL);
    assign cmd_valid = q_valid_reg;
    assign cmd       = q_cmd_reg;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (cmd_take)
        begin
            q_valid_next = 1'b0;
        end
        if (is_mul)
        begin
            q_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_mul)
        begin
            q_cmd_reg <= '{adj1: in_item.adjoint_first, adj2: in_item.adjoint_second};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cmpa_back.sv =====
// Back end: sequences the product, one complex multiply-accumulate at a time.
// Depends on cmpa_pkg.
`default_nettype none
module cmpa_back #(
    parameter int DIM = cmpa_pkg::DIM_DEF,
    parameter int FRAC_BITS = cmpa_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(DIM * DIM),
    localparam int CW = $clog2(DIM)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmpa_pkg::cmd_t     cmd,
    output logic                    cmd_take,
    output logic                    busy,
    output logic [AW-1:0]           raddr_a,
    output logic [AW-1:0]           raddr_b,
    input  wire logic [63:0]        rdata_a,
    input  wire logic [63:0]        rdata_b,
    output logic                    empty,
    input  wire logic               pop,
    output cmpa_pkg::out_item_t     out_item
);
    localparam int AXW = cmpa_pkg::ACC_W;
    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_ACC, S_OUT} state_t;

    state_t state_reg;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic adj1_reg, adj2_reg, last_k_reg;
    logic signed [63:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [AXW-1:0] re_reg, im_reg;
    logic out_valid_reg;
    cmpa_pkg::out_item_t out_reg;
    logic [2*AW-1:0] ia, ib;
    logic signed [AXW-1:0] re_sum, im_sum;
    logic last_k, last_j, last_i;

    function automatic logic signed [31:0] rnd_sat(input logic signed [AXW-1:0] v);
        logic signed [AXW-1:0] r;
        r = (v + (AXW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > AXW'(32'sh7FFFFFFF))
            rnd_sat = 32'sh7FFFFFFF;
        else if (r < -(AXW'(64'sh80000000)))
            rnd_sat = 32'sh80000000;
        else
            rnd_sat = r[31:0];
    endfunction

    assign ia = adj1_reg ? (2*AW)'(k_reg) * (2*AW)'(DIM) + (2*AW)'(i_reg)
                         : (2*AW)'(i_reg) * (2*AW)'(DIM) + (2*AW)'(k_reg);
    assign ib = adj2_reg ? (2*AW)'(j_reg) * (2*AW)'(DIM) + (2*AW)'(k_reg)
                         : (2*AW)'(k_reg) * (2*AW)'(DIM) + (2*AW)'(j_reg);
    assign raddr_a = ia[AW-1:0];
    assign raddr_b = ib[AW-1:0];
    assign last_k  = (32'(k_reg) == DIM - 1);
    assign last_j  = (32'(j_reg) == DIM - 1);
    assign last_i  = (32'(i_reg) == DIM - 1);
    assign re_sum  = re_reg + AXW'(rr_reg) + ((adj1_reg == adj2_reg) ? -AXW'(ii_reg)
                                                                    : AXW'(ii_reg));
    assign im_sum  = im_reg + (adj2_reg ? -AXW'(ri_reg) : AXW'(ri_reg))
                            + (adj1_reg ? -AXW'(ir_reg) : AXW'(ir_reg));
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign busy     = (state_reg != S_IDLE);
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            adj1_reg      <= 1'b0;
            adj2_reg      <= 1'b0;
            last_k_reg    <= 1'b0;
            rr_reg        <= '0;
            ii_reg        <= '0;
            ri_reg        <= '0;
            ir_reg        <= '0;
            re_reg        <= '0;
            im_reg        <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        adj1_reg  <= cmd.adj1;
                        adj2_reg  <= cmd.adj2;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        re_reg    <= '0;
                        im_reg    <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    last_k_reg <= last_k;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    rr_reg    <= 64'(signed'(rdata_a[31:0])) * 64'(signed'(rdata_b[31:0]));
                    ii_reg    <= 64'(signed'(rdata_a[63:32])) * 64'(signed'(rdata_b[63:32]));
                    ri_reg    <= 64'(signed'(rdata_a[31:0])) * 64'(signed'(rdata_b[63:32]));
                    ir_reg    <= 64'(signed'(rdata_a[63:32])) * 64'(signed'(rdata_b[31:0]));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    re_reg <= re_sum;
                    im_reg <= im_sum;
                    if (last_k_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.out_row     <= 2'(i_reg);
                        out_reg.out_col     <= 2'(j_reg);
                        out_reg.out_real    <= rnd_sat(re_reg);
                        out_reg.out_imag    <= rnd_sat(im_reg);
                        out_reg.last_of_run <= last_i && last_j;
                        re_reg              <= '0;
                        im_reg              <= '0;
                        k_reg               <= '0;
                        if (last_j)
                        begin
                            j_reg <= '0;
                            if (last_i)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_READ;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/complex_matrix_product_adjoint.sv =====
// Complex matrix product with optional conjugate transposes of either operand.
// Depends on cmpa_pkg, cmpa_front, cmpa_back, cmpa_ram and the assert header.
//
// Input channel: queue style, push/full carrying in_item. Actions load one
// element of the first or second matrix (row, col, real, imag) or start a
// multiply with two adjoint flags. Loads are written when accepted; out-of-range
// loads and the unused action are dropped.
// Output channel: queue style, empty/pop carrying out_item. A multiply gives
// DIM*DIM items in row-major order, the last one flagged by last_of_run.
// Each product element is formed term by term through one shared complex
// multiplier (read, multiply and accumulate per term), then output; the
// back end works on one element at a time.
// A multiply waits in the queue until the back end is idle; full stays high
// while one waits or runs, so items behind it wait until its last element
// has been computed.
// When the receiver stalls the finished item holds on the output and the
// back end waits before writing the next one.
// Reset clears the queue and sequencer; matrix contents are undefined until
// loaded.
`default_nettype none
`include "complex_matrix_product_adjoint_assert.svh"
module complex_matrix_product_adjoint #(
    parameter int DIM = cmpa_pkg::DIM_DEF,
    parameter int FRAC_BITS = cmpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire cmpa_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output cmpa_pkg::out_item_t      out_item
);
    localparam int AW = $clog2(DIM * DIM);

    logic          we_a, we_b, cmd_valid, cmd_take, busy;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [63:0]   wdata, rdata_a, rdata_b;
    cmpa_pkg::cmd_t cmd;

    cmpa_front #(.DIM(DIM)) u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .we_a, .we_b, .waddr, .wdata, .cmd_valid, .cmd, .cmd_take, .busy
    );

    cmpa_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_ram_a (
        .clk, .we(we_a), .waddr, .wdata, .raddr(raddr_a), .rdata(rdata_a)
    );

    cmpa_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_ram_b (
        .clk, .we(we_b), .waddr, .wdata, .raddr(raddr_b), .rdata(rdata_b)
    );

    cmpa_back #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .busy,
        .raddr_a, .raddr_b, .rdata_a, .rdata_b, .empty, .pop, .out_item
    );

    `CMPA_ASSERT_IMP(a_no_write_when_full, full, !we_a && !we_b, "write while full")
    `CMPA_ASSERT_NEXT(a_take_clears, cmd_take, !cmd_valid, "queue not freed")
    `CMPA_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item), "output dropped")
endmodule
`default_nettype wire

// ===== tb/sv/cmpa_product_checker.sv =====
// Checker for the complex matrix product block: watches both queue channels,
// predicts product elements from its own copy of the matrices and compares.
// Depends on cmpa_pkg.
module cmpa_product_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  cmpa_pkg::in_item_t  in_item,
    input  logic                empty,
    input  logic                pop,
    input  cmpa_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  pending,
    output int                  products_seen
);
    localparam int N = cmpa_pkg::DIM_DEF;
    localparam int FB = cmpa_pkg::FRAC_BITS_DEF;

    logic [63:0]         mat_a [N*N];
    logic [63:0]         mat_b [N*N];
    cmpa_pkg::out_item_t product_queue [$];

    function automatic logic signed [31:0] round_sat(logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
        if (r > 128'sd2147483647)
            return 32'sh7fffffff;
        if (r < -128'sd2147483648)
            return 32'sh80000000;
        return r[31:0];
    endfunction

    task automatic predict_product(logic adj1, logic adj2);
        logic [63:0]         x, y;
        logic signed [127:0] re, im, xr, xi, yr, yi;
        cmpa_pkg::out_item_t o;
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                re = 0;
                im = 0;
                for (int k = 0; k < N; k++)
                begin
                    x = adj1 ? mat_a[k*N+i] : mat_a[i*N+k];
                    y = adj2 ? mat_b[j*N+k] : mat_b[k*N+j];
                    xr = $signed(x[31:0]);
                    xi = $signed(x[63:32]);
                    yr = $signed(y[31:0]);
                    yi = $signed(y[63:32]);
                    if (adj1)
                        xi = -xi;
                    if (adj2)
                        yi = -yi;
                    re = re + xr * yr - xi * yi;
                    im = im + xr * yi + xi * yr;
                end
                o.out_row = i[1:0];
                o.out_col = j[1:0];
                o.out_real = round_sat(re);
                o.out_imag = round_sat(im);
                o.last_of_run = (i == N - 1 && j == N - 1);
                product_queue.push_back(o);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_queue.delete();
            fail_count <= 0;
            pending <= 0;
            products_seen <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                case (in_item.action)
                    cmpa_pkg::ACT_LOAD_A:
                        if (in_item.row < N && in_item.col < N)
                            mat_a[in_item.row*N+in_item.col] =
                                {in_item.imag_part, in_item.real_part};
                    cmpa_pkg::ACT_LOAD_B:
                        if (in_item.row < N && in_item.col < N)
                            mat_b[in_item.row*N+in_item.col] =
                                {in_item.imag_part, in_item.real_part};
                    cmpa_pkg::ACT_MUL:
                        predict_product(in_item.adjoint_first, in_item.adjoint_second);
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (product_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected item: %p", out_item);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (out_item !== product_queue[0])
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p",
                                     product_queue[0], out_item);
                        fail_count <= fail_count + 1;
                    end
                    if (product_queue[0].last_of_run)
                        products_seen <= products_seen + 1;
                    void'(product_queue.pop_front());
                end
            end
            pending <= product_queue.size();
        end
    end
endmodule

// ===== tb/sv/tb_complex_matrix_product_adjoint.sv =====
// Testbench top for the complex matrix product block: drives loads and
// multiplies under several idle patterns and gives the verdict.
// Depends on cmpa_pkg, cmpa_product_checker and the block.
module tb_complex_matrix_product_adjoint;
    localparam int LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    cmpa_pkg::in_item_t  in_item;
    logic                empty;
    logic                pop;
    cmpa_pkg::out_item_t out_item;
    int                  fail_count;
    int                  pending;
    int                  products_seen;
    int                  cycles;
    int                  pop_pct;
    int                  push_idle_pct;
    int                  items_sent;

    complex_matrix_product_adjoint u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    cmpa_product_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .fail_count(fail_count),
        .pending(pending), .products_seen(products_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("complex_matrix_product_adjoint regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_pct);

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(32'h1fffffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(cmpa_pkg::in_item_t it);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic load(logic [1:0] act, int r, int c, logic [31:0] re, logic [31:0] im);
        cmpa_pkg::in_item_t it;
        it.action = act;
        it.row = r[1:0];
        it.col = c[1:0];
        it.real_part = re;
        it.imag_part = im;
        it.adjoint_first = 1'($urandom);
        it.adjoint_second = 1'($urandom);
        send(it);
    endtask

    task automatic multiply(logic a1, logic a2);
        cmpa_pkg::in_item_t it;
        it = cmpa_pkg::in_item_t'($bits(cmpa_pkg::in_item_t)'({$urandom, $urandom, $urandom}));
        it.action = cmpa_pkg::ACT_MUL;
        it.adjoint_first = a1;
        it.adjoint_second = a2;
        send(it);
    endtask

    task automatic fill_both(int mode);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                if (mode == 0)
                begin
                    load(cmpa_pkg::ACT_LOAD_A, r, c, rand_part(), rand_part());
                    load(cmpa_pkg::ACT_LOAD_B, r, c, rand_part(), rand_part());
                end
                else
                begin
                    load(cmpa_pkg::ACT_LOAD_A, r, c,
                         mode == 1 ? 32'h80000000 : 32'h7fffffff, 32'h80000000);
                    load(cmpa_pkg::ACT_LOAD_B, r, c, 32'h80000000,
                         mode == 1 ? 32'h80000000 : 32'h7fffffff);
                end
            end
    endtask

    task automatic random_item();
        cmpa_pkg::in_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            load(cmpa_pkg::ACT_LOAD_A, $urandom_range(2), $urandom_range(2),
                 rand_part(), rand_part());
        else if (pick < 80)
            load(cmpa_pkg::ACT_LOAD_B, $urandom_range(2), $urandom_range(2),
                 rand_part(), rand_part());
        else if (pick < 92)
            multiply(1'($urandom), 1'($urandom));
        else
        begin
            it = cmpa_pkg::in_item_t'($bits(cmpa_pkg::in_item_t)'({$urandom, $urandom,
                                                                    $urandom}));
            if (it.action == cmpa_pkg::ACT_MUL)
                it.action = cmpa_pkg::ACT_NONE;
            if (it.action != cmpa_pkg::ACT_NONE)
                it.row = 2'd3;
            send(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        cycles = 0;
        pop_pct = 0;
        push_idle_pct = 0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fill_both(1);
        multiply(1'b0, 1'b0);
        multiply(1'b1, 1'b1);
        fill_both(2);
        multiply(1'b1, 1'b0);
        multiply(1'b0, 1'b1);
        load(cmpa_pkg::ACT_LOAD_A, 3, 0, 32'h1, 32'h1);
        load(cmpa_pkg::ACT_LOAD_B, 1, 3, 32'h1, 32'h1);
        load(cmpa_pkg::ACT_NONE, 0, 0, 32'h1, 32'h1);
        multiply(1'b0, 1'b0);
        fill_both(0);

        for (int ph = 0; ph < 4; ph++)
        begin
            push_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 24 : 83) : 0;
            pop_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 24 : 83) : 0;
            for (int n = 0; n < 27; n++)
                random_item();
        end
        push <= 1'b0;
        push_idle_pct = 0;
        pop_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items, checked %0d products over four idle patterns",
                 items_sent, products_seen);
        if (fail_count == 0 && pending == 0)
            $display("complex_matrix_product_adjoint regression: pass");
        else
            $display("complex_matrix_product_adjoint regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cmpa_pkg.sv
rtl/cmpa_ram.sv
rtl/cmpa_front.sv
rtl/cmpa_back.sv
rtl/complex_matrix_product_adjoint.sv
tb/sv/cmpa_product_checker.sv
tb/sv/tb_complex_matrix_product_adjoint.sv
